// ===== src/dip_pkg.sv =====
`default_nettype none
package dip_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  // low byte of a finished part plus its over-255 flag in the top bit
  typedef logic [8:0] part_t;

  typedef struct packed {
    phase_t           phase;
    base_t            base;
    logic [31:0]      value;
    logic [2:0][8:0]  parts;
    logic [1:0]       count;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       string_start;
  } char_beat_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] address_value;
  } result_beat_t;

  localparam logic [31:0] LAST_MAX_24 = 32'h00ff_ffff;
  localparam logic [31:0] LAST_MAX_16 = 32'h0000_ffff;
  localparam logic [31:0] LAST_MAX_8  = 32'h0000_00ff;
  localparam logic [1:0]  MAX_DOTS    = 2'd3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_LX   = 8'h78;

endpackage
`default_nettype wire

// ===== src/dip_step.sv =====
`default_nettype none
module dip_step (
  input  dip_pkg::parse_state_t st,
  input  dip_pkg::char_beat_t   beat,
  output dip_pkg::parse_state_t st_next,
  output logic                  emit,
  output dip_pkg::result_beat_t res
);

  dip_pkg::parse_state_t cur;
  logic [7:0]  c;
  logic        is_dec;
  logic        is_hex_letter;
  logic        is_blank;
  logic [3:0]  hex_letter;
  logic [31:0] times8;
  logic [31:0] times10;
  logic [31:0] times16;
  logic        fin_ok;
  logic [31:0] fin_addr;
  logic        do_digit;

  assign c             = beat.text_char;
  assign is_dec        = (c >= dip_pkg::CH_0) && (c <= dip_pkg::CH_9);
  assign is_hex_letter = ((c >= dip_pkg::CH_LA) && (c <= dip_pkg::CH_LF)) ||
                         ((c >= dip_pkg::CH_UA) && (c <= dip_pkg::CH_UF));
  assign is_blank      = (c == dip_pkg::CH_SP) ||
                         ((c >= dip_pkg::CH_TAB) && (c <= dip_pkg::CH_CR));
  // 'a'..'f' and 'A'..'F' share the low three bits 1..6
  assign hex_letter    = {1'b0, c[2:0]} + 4'd9;

  // a new start clears base, value, parts and count and begins at the first character of a part
  always_comb begin
    cur = st;
    if (beat.string_start) begin
      cur.phase = dip_pkg::PH_FIRST;
      cur.base  = dip_pkg::BASE_DEC;
      cur.value = '0;
      cur.parts = '0;
      cur.count = '0;
    end
  end

  assign times8  = {cur.value[28:0], 3'b000};
  assign times16 = {cur.value[27:0], 4'b0000};
  assign times10 = times8 + {cur.value[30:0], 1'b0};

  always_comb begin
    fin_ok   = 1'b1;
    fin_addr = cur.value;
    case (cur.count)
      2'd0: begin
        fin_ok   = 1'b1;
        fin_addr = cur.value;
      end
      2'd1: begin
        fin_ok   = !(cur.value > dip_pkg::LAST_MAX_24) && !cur.parts[0][8];
        fin_addr = cur.value | {cur.parts[0][7:0], 24'd0};
      end
      2'd2: begin
        fin_ok   = !(cur.value > dip_pkg::LAST_MAX_16) && !cur.parts[0][8] &&
                   !cur.parts[1][8];
        fin_addr = cur.value | {cur.parts[0][7:0], cur.parts[1][7:0], 16'd0};
      end
      default: begin
        fin_ok   = !(cur.value > dip_pkg::LAST_MAX_8) && !cur.parts[0][8] &&
                   !cur.parts[1][8] && !cur.parts[2][8];
        fin_addr = cur.value | {cur.parts[0][7:0], cur.parts[1][7:0],
                                cur.parts[2][7:0], 8'd0};
      end
    endcase
  end

  always_comb begin
    st_next           = cur;
    emit              = 1'b0;
    res.parse_ok      = 1'b0;
    res.address_value = '0;
    do_digit          = 1'b0;

    case (cur.phase)
      dip_pkg::PH_FIRST: begin
        if (!is_dec) begin
          emit = 1'b1;
        end else begin
          st_next.base  = dip_pkg::BASE_DEC;
          st_next.value = {28'd0, c[3:0]};
          if (c == dip_pkg::CH_0) begin
            st_next.phase = dip_pkg::PH_ZERO;
          end else begin
            st_next.phase = dip_pkg::PH_DIGITS;
          end
        end
      end
      dip_pkg::PH_ZERO: begin
        st_next.phase = dip_pkg::PH_DIGITS;
        if (c == dip_pkg::CH_LX || c == dip_pkg::CH_UX) begin
          st_next.base = dip_pkg::BASE_HEX;
        end else begin
          st_next.base = dip_pkg::BASE_OCT;
          do_digit     = 1'b1;
        end
      end
      dip_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
        do_digit = 1'b0;
      end
    endcase

    if (do_digit) begin
      if (is_dec) begin
        case (st_next.base)
          dip_pkg::BASE_HEX: st_next.value = times16 + {28'd0, c[3:0]};
          dip_pkg::BASE_OCT: st_next.value = times8 + {28'd0, c[3:0]};
          default:           st_next.value = times10 + {28'd0, c[3:0]};
        endcase
      end else if (st_next.base == dip_pkg::BASE_HEX && is_hex_letter) begin
        st_next.value = times16 | {28'd0, hex_letter};
      end else if (c == dip_pkg::CH_DOT) begin
        if (cur.count == dip_pkg::MAX_DOTS) begin
          emit = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (cur.count == 2'(i)) begin
              st_next.parts[i] = {(|cur.value[31:8]), cur.value[7:0]};
            end
          end
          st_next.count = cur.count + 2'd1;
          st_next.phase = dip_pkg::PH_FIRST;
        end
      end else if (c != dip_pkg::CH_NUL && !is_blank) begin
        emit = 1'b1;
      end else begin
        emit              = 1'b1;
        res.parse_ok      = fin_ok;
        res.address_value = fin_ok ? fin_addr : 32'd0;
      end
    end

    if (emit) begin
      st_next.phase = dip_pkg::PH_IDLE;
    end
  end

endmodule
`default_nettype wire

// ===== src/dotted_ipv4_text_parser.sv =====
// Streaming parser for dotted IPv4 text (inet_aton rules: one to four parts, each decimal,
// octal with a leading 0 or hex with 0x). Characters arrive one per beat on the char channel,
// string_start set on the first. A new character is taken every cycle, except that char_stall
// rises while a result waits under result_stall and the input register is also full. A
// character waits in the input register until it is processed; then the parse state (a 32-bit
// multiply-by-base and add) is updated and its result, if it decides the parse, is loaded into
// the result register. At most one result comes per string, on the terminating or failing
// character; later characters are dropped until the next string_start. address_value is in
// host order, first part in bits 31..24, and is zero when parse_ok is low.
`default_nettype none
module dotted_ipv4_text_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  dip_pkg::char_beat_t   char_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output dip_pkg::result_beat_t result_data
);

  logic                  hold_valid;
  dip_pkg::char_beat_t   hold_beat;
  dip_pkg::parse_state_t state;
  dip_pkg::parse_state_t state_next;
  logic                  step_emit;
  dip_pkg::result_beat_t step_res;
  logic                  result_free;
  logic                  fire;
  logic                  accept;

  assign result_free = !result_valid || !result_stall;
  assign fire        = hold_valid && result_free;
  assign char_stall  = hold_valid && !result_free;
  assign accept      = char_valid && !char_stall;

  dip_step u_step (
    .st      (state),
    .beat    (hold_beat),
    .st_next (state_next),
    .emit    (step_emit),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_beat <= char_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= dip_pkg::PH_IDLE;
      state.base  <= dip_pkg::BASE_DEC;
      state.value <= '0;
      state.parts <= '0;
      state.count <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register: valid reloaded whenever the held character is processed, data only when it decides the parse
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= step_emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_emit) begin
      result_data <= step_res;
    end
  end

endmodule
`default_nettype wire

// ===== tb/ipv4_parse_checker.sv =====
module ipv4_parse_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  logic                  char_stall,
  input  dip_pkg::char_beat_t   char_data,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  dip_pkg::result_beat_t result_data,
  output int                    fail_count,
  output int                    results_owed,
  output int                    chars_parsed
);
  timeunit 1ns;
  timeprecision 1ps;

  dip_pkg::phase_t       ph;
  dip_pkg::base_t        base;
  logic [31:0]           acc;
  dip_pkg::part_t        done_parts [3];
  logic [1:0]            done_count;
  dip_pkg::result_beat_t addr_expect_q [$];
  dip_pkg::result_beat_t predicted;
  dip_pkg::result_beat_t oldest;

  initial fail_count = 0;

  function automatic void clear_parse();
    base = dip_pkg::BASE_DEC;
    acc = '0;
    done_parts = '{default: '0};
    done_count = '0;
  endfunction

  function automatic bit finish_with(bit ok, logic [31:0] addr,
                                     output dip_pkg::result_beat_t r);
    ph = dip_pkg::PH_IDLE;
    r.parse_ok = ok;
    r.address_value = ok ? addr : '0;
    return 1'b1;
  endfunction

  // last part fills whatever low bits the finished parts leave
  function automatic bit close_address(output dip_pkg::result_beat_t r);
    bit          ok;
    logic [31:0] addr;
    case (done_count)
      2'd0: begin
        ok = 1'b1;
        addr = acc;
      end
      2'd1: begin
        ok = acc <= dip_pkg::LAST_MAX_24 && !done_parts[0][8];
        addr = acc | {done_parts[0][7:0], 24'h0};
      end
      2'd2: begin
        ok = acc <= dip_pkg::LAST_MAX_16 && !done_parts[0][8] && !done_parts[1][8];
        addr = acc | {done_parts[0][7:0], 24'h0} | {8'h0, done_parts[1][7:0], 16'h0};
      end
      default: begin
        ok = acc <= dip_pkg::LAST_MAX_8 && !done_parts[0][8] && !done_parts[1][8]
             && !done_parts[2][8];
        addr = acc | {done_parts[0][7:0], 24'h0} | {8'h0, done_parts[1][7:0], 16'h0}
               | {16'h0, done_parts[2][7:0], 8'h0};
      end
    endcase
    return finish_with(ok, addr, r);
  endfunction

  function automatic bit take_part_char(logic [7:0] c, output dip_pkg::result_beat_t r);
    logic [31:0] radix;
    r = '0;
    radix = (base == dip_pkg::BASE_HEX) ? 32'd16 :
            (base == dip_pkg::BASE_OCT) ? 32'd8 : 32'd10;
    if (c >= dip_pkg::CH_0 && c <= dip_pkg::CH_9) begin
      // octal takes 8 and 9 too, and the part wraps at 32 bits
      acc = acc * radix + 32'(c - dip_pkg::CH_0);
      return 1'b0;
    end
    if (base == dip_pkg::BASE_HEX && c >= dip_pkg::CH_LA && c <= dip_pkg::CH_LF) begin
      acc = {acc[27:0], 4'(c - dip_pkg::CH_LA + 8'd10)};
      return 1'b0;
    end
    if (base == dip_pkg::BASE_HEX && c >= dip_pkg::CH_UA && c <= dip_pkg::CH_UF) begin
      acc = {acc[27:0], 4'(c - dip_pkg::CH_UA + 8'd10)};
      return 1'b0;
    end
    if (c == dip_pkg::CH_DOT) begin
      if (done_count == dip_pkg::MAX_DOTS)
        return finish_with(1'b0, '0, r);
      done_parts[done_count] = {acc > dip_pkg::LAST_MAX_8, acc[7:0]};
      done_count++;
      ph = dip_pkg::PH_FIRST;
      return 1'b0;
    end
    if (c != dip_pkg::CH_NUL &&
        !(c == dip_pkg::CH_SP || (c >= dip_pkg::CH_TAB && c <= dip_pkg::CH_CR)))
      return finish_with(1'b0, '0, r);
    return close_address(r);
  endfunction

  function automatic bit step_parser(dip_pkg::char_beat_t b,
                                     output dip_pkg::result_beat_t r);
    r = '0;
    if (b.string_start) begin
      clear_parse();
      ph = dip_pkg::PH_FIRST;
    end
    case (ph)
      dip_pkg::PH_FIRST: begin
        if (b.text_char < dip_pkg::CH_0 || b.text_char > dip_pkg::CH_9)
          return finish_with(1'b0, '0, r);
        acc = '0;
        base = dip_pkg::BASE_DEC;
        if (b.text_char == dip_pkg::CH_0) begin
          ph = dip_pkg::PH_ZERO;
        end else begin
          acc = 32'(b.text_char - dip_pkg::CH_0);
          ph = dip_pkg::PH_DIGITS;
        end
        return 1'b0;
      end
      dip_pkg::PH_ZERO: begin
        ph = dip_pkg::PH_DIGITS;
        if (b.text_char == dip_pkg::CH_LX || b.text_char == dip_pkg::CH_UX) begin
          base = dip_pkg::BASE_HEX;
          return 1'b0;
        end
        base = dip_pkg::BASE_OCT;
        return take_part_char(b.text_char, r);
      end
      dip_pkg::PH_DIGITS: return take_part_char(b.text_char, r);
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      ph = dip_pkg::PH_IDLE;
      addr_expect_q.delete();
      chars_parsed = 0;
    end else begin
      if (char_valid && !char_stall) begin
        chars_parsed++;
        if (step_parser(char_data, predicted))
          addr_expect_q.push_back(predicted);
      end
      if (result_valid && !result_stall) begin
        if (addr_expect_q.size() == 0) begin
          $error("unexpected result beat: parse_ok %0b address_value %h",
                 result_data.parse_ok, result_data.address_value);
          fail_count++;
        end else begin
          oldest = addr_expect_q.pop_front();
          if (result_data.parse_ok !== oldest.parse_ok) begin
            $error("parse_ok expected %0b got %0b", oldest.parse_ok, result_data.parse_ok);
            fail_count++;
          end
          if (result_data.address_value !== oldest.address_value) begin
            $error("address_value expected %h got %h", oldest.address_value,
                   result_data.address_value);
            fail_count++;
          end
        end
      end
    end
    results_owed = addr_expect_q.size();
  end

endmodule

// ===== tb/tb_dotted_ipv4_text_parser.sv =====
module tb_dotted_ipv4_text_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_GOAL   = 1750;
  localparam int LONG_HOLD   = 150;
  localparam int TAIL_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  char_valid;
  logic                  char_stall;
  dip_pkg::char_beat_t   char_data;
  logic                  result_valid;
  logic                  result_stall;
  dip_pkg::result_beat_t result_data;

  int fail_count;
  int results_owed;
  int chars_parsed;

  bit calm;
  bit tx_idle;
  bit rx_idle;
  bit hold_now;

  dip_pkg::char_beat_t line_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dotted_ipv4_text_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  ipv4_parse_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .chars_parsed (chars_parsed)
  );

  function automatic void put_char(logic [7:0] c, bit st);
    line_q.push_back(dip_pkg::char_beat_t'{text_char: c, string_start: st});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++)
      put_char(s[i], line_q.size() == 0);
  endfunction

  function automatic logic [7:0] terminator();
    int k;
    k = $urandom_range(0, 6);
    case (k)
      0: return dip_pkg::CH_NUL;
      1: return dip_pkg::CH_SP;
      default: return dip_pkg::CH_TAB + 8'(k - 2);
    endcase
  endfunction

  function automatic logic [31:0] part_value(bit last, int nparts);
    logic [31:0] mask;
    if (!last)
      return ($urandom_range(0, 7) == 0) ? 32'($urandom_range(256, 70000))
                                         : 32'($urandom_range(0, 255));
    mask = (nparts == 1) ? 32'hffff_ffff : (32'h1 << (32 - 8 * (nparts - 1))) - 1;
    case ($urandom_range(0, 9))
      0: return mask;
      1: return '0;
      2: return (nparts == 1) ? $urandom : mask + 1 + $urandom_range(0, 300);
      3: return $urandom_range(0, 255);
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic string part_text(logic [31:0] v);
    string s;
    case ($urandom_range(0, 3))
      0: begin
        s = $sformatf("0%0o", v);
        // octal parts still take 8 and 9
        if ($urandom_range(0, 5) == 0)
          s[$urandom_range(1, s.len() - 1)] = dip_pkg::CH_9 - 8'($urandom_range(0, 1));
      end
      1: begin
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++)
          if (s[i] >= dip_pkg::CH_LA && s[i] <= dip_pkg::CH_LF && $urandom_range(0, 1) == 1)
            s[i] = s[i] - 8'h20;
        if ($urandom_range(0, 1) == 1)
          s = {"0x", s};
        else
          s = {"0X", s};
      end
      default: s = $sformatf("%0d", v);
    endcase
    return s;
  endfunction

  // decimal parts of 10 to 14 digits, which can wrap past 32 bits
  function automatic string long_decimal();
    string s;
    int    n;
    s = $sformatf("%0d", $urandom_range(1, 9));
    n = $urandom_range(9, 13);
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic void build_address(int nparts);
    for (int p = 0; p < nparts; p++) begin
      if (p > 0)
        put_char(dip_pkg::CH_DOT, 1'b0);
      if ($urandom_range(0, 15) == 0)
        put_text(long_decimal());
      else
        put_text(part_text(part_value(p == nparts - 1 && nparts < 5, nparts)));
    end
  endfunction

  function automatic void random_line();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      put_char(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    if (kind < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) put_char(8'($urandom_range(0, 255)), line_q.size() == 0);
      return;
    end
    build_address(kind < 22 ? 5 : $urandom_range(1, 4));
    if (kind < 32) begin
      // unfinished, the next start abandons it
      n = $urandom_range(1, line_q.size());
      while (line_q.size() > n) void'(line_q.pop_back());
      return;
    end
    put_char(terminator(), 1'b0);
    if (kind < 45) begin
      n = $urandom_range(1, line_q.size());
      line_q.insert(n, dip_pkg::char_beat_t'{text_char: 8'($urandom_range(0, 255)),
                                             string_start: 1'b0});
    end else if (kind < 65) begin
      n = $urandom_range(1, 3);
      repeat (n) put_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  task automatic push_char(dip_pkg::char_beat_t b);
    char_data <= b;
    char_valid <= 1'b1;
    do @(posedge clk); while (char_stall);
    if (tx_idle && !calm && $urandom_range(0, 7) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) push_char(line_q[i]);
    line_q.delete();
  endtask

  // receiver side
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
        hold_now = 1'b0;
      end else if (rx_idle && !calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    bit hold_done;
    bit drain_done;
    int guard;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst <= 1'b1;
    char_valid <= 1'b0;
    char_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    put_text("0xFf");
    put_char(dip_pkg::CH_NUL, 1'b0);
    send_line();
    put_text("09");
    put_char(dip_pkg::CH_NUL, 1'b0);
    send_line();
    put_text("0X");
    put_char(dip_pkg::CH_SP, 1'b0);
    send_line();
    put_char("q", 1'b0);
    send_line();
    put_text("a");
    send_line();
    put_text("1#");
    send_line();
    put_text("12");
    send_line();
    put_text("3");
    put_char(dip_pkg::CH_TAB, 1'b0);
    send_line();
    put_char(8'hff, 1'b1);
    send_line();
    put_text("256.0");
    put_char(dip_pkg::CH_CR, 1'b0);
    send_line();

    while (chars_parsed < CHAR_GOAL) begin
      if (!hold_done && chars_parsed >= 400) begin
        // back-to-back failing strings while the result side is held off
        tx_idle = 1'b0;
        hold_now = 1'b1;
        repeat (40) begin
          put_char("z", 1'b1);
          send_line();
        end
        hold_done = 1'b1;
      end else if (!drain_done && chars_parsed >= 1000) begin
        char_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        drain_done = 1'b1;
      end
      calm = chars_parsed >= 1500;
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      random_line();
      send_line();
    end

    char_valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (results_owed != 0 && guard < 20000);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_owed != 0)
      $error("%0d address results never arrived", results_owed);
    if (fail_count == 0 && results_owed == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/dip_pkg.sv
src/dip_step.sv
src/dotted_ipv4_text_parser.sv
tb/ipv4_parse_checker.sv
tb/tb_dotted_ipv4_text_parser.sv
